// File: hdl/gbn_pkg.sv
// Shared types and constants for the go-back-n send window.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package gbn_pkg;

  localparam int unsigned WIN_MAX   = 8;
  localparam int unsigned SEQ_BITS  = 16;
  localparam int unsigned SLOT_BITS = 3;
  localparam int unsigned IDX_BITS  = 3;
  localparam int unsigned CNT_BITS  = 4;
  localparam int unsigned WIN_BITS  = 4;

  localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(3);

  // input command codes
  localparam logic [1:0] CMD_OFFER   = 2'd0;
  localparam logic [1:0] CMD_ACK     = 2'd1;
  localparam logic [1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_NEW    = 2'd0;
  localparam logic [1:0] KIND_RESEND = 2'd1;
  localparam logic [1:0] KIND_REFUSE = 2'd2;
  localparam logic [1:0] KIND_STATUS = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic                do_offer;
    logic                do_ack;
    logic                do_resend;
    logic [IDX_BITS-1:0] idx;
    logic                idx_last;
  } gbn_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic                out_free;
    logic [CNT_BITS-1:0] outstanding;
  } gbn_stat_t;

endpackage

// File: hdl/gbn_ctrl.sv
// Sequencing controller for the go-back-n send window.
// Uses gbn_pkg; drives gbn_dp through gbn_cmd_t and reads gbn_stat_t.
module gbn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  input  gbn_pkg::gbn_stat_t stat_i,
  output gbn_pkg::gbn_cmd_t  cmd_o
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_RESEND = 1'b1;

  logic                         state_q, state_d;
  logic [gbn_pkg::IDX_BITS-1:0] idx_q, idx_d;
  logic [gbn_pkg::CNT_BITS-1:0] cnt_q, cnt_d;
  logic                         accept;
  logic [gbn_pkg::CNT_BITS-1:0] idx_next;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;
  assign idx_next   = gbn_pkg::CNT_BITS'(idx_q) + gbn_pkg::CNT_BITS'(1);

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            gbn_pkg::CMD_OFFER: cmd_o.do_offer = 1'b1;
            gbn_pkg::CMD_ACK:   cmd_o.do_ack   = 1'b1;
            gbn_pkg::CMD_TIMEOUT: begin
              if (stat_i.outstanding != '0) begin
                cmd_o.do_resend = 1'b1;
                cmd_o.idx       = '0;
                cmd_o.idx_last  = (stat_i.outstanding == gbn_pkg::CNT_BITS'(1));
                if (!cmd_o.idx_last) begin
                  state_d = ST_RESEND;
                  idx_d   = gbn_pkg::IDX_BITS'(1);
                  cnt_d   = stat_i.outstanding;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_RESEND: begin
        if (stat_i.out_free) begin
          cmd_o.do_resend = 1'b1;
          cmd_o.idx       = idx_q;
          cmd_o.idx_last  = (idx_next == cnt_q);
          if (cmd_o.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_next[gbn_pkg::IDX_BITS-1:0];
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// File: hdl/gbn_dp.sv
// Window state, window-size register and result register of the go-back-n sender.
// Uses gbn_pkg; steered by gbn_ctrl through gbn_cmd_t.
module gbn_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [gbn_pkg::WIN_BITS-1:0]  cfg_window_size_i,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq_i,
  input  logic                          chunk_final_i,
  input  gbn_pkg::gbn_cmd_t             cmd_i,
  output gbn_pkg::gbn_stat_t            stat_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [gbn_pkg::SEQ_BITS-1:0]  seq_o,
  output logic [gbn_pkg::SLOT_BITS-1:0] slot_o,
  output logic                          final_flag_o,
  output logic                          done_res_o,
  output logic                          last_o
);

  logic [gbn_pkg::WIN_BITS-1:0]  win_q;
  logic [gbn_pkg::SEQ_BITS-1:0]  base_q, base_d, next_q, next_d, final_q, final_d;
  logic                          final_sent_q, final_sent_d, finished_q, finished_d;
  logic [gbn_pkg::SEQ_BITS-1:0]  diff, ack_off, rs_seq, ack_plus;
  logic [gbn_pkg::CNT_BITS-1:0]  outstanding, eff_win;
  logic                          offer_ok, ack_ok;

  logic                          ov_q, ov_d;
  logic [1:0]                    kind_q, kind_d;
  logic [gbn_pkg::SEQ_BITS-1:0]  seq_q, seq_d;
  logic [gbn_pkg::SLOT_BITS-1:0] slot_q, slot_d;
  logic                          fin_q, fin_d, done_q, done_d, last_q, last_d;

  assign diff = next_q - base_q;
  assign outstanding = (diff > gbn_pkg::SEQ_BITS'(gbn_pkg::WIN_MAX))
                     ? gbn_pkg::CNT_BITS'(gbn_pkg::WIN_MAX) : diff[gbn_pkg::CNT_BITS-1:0];
  assign eff_win = (win_q == '0) ? gbn_pkg::CNT_BITS'(1)
                 : (win_q > gbn_pkg::WIN_BITS'(gbn_pkg::WIN_MAX))
                   ? gbn_pkg::CNT_BITS'(gbn_pkg::WIN_MAX) : gbn_pkg::CNT_BITS'(win_q);
  assign offer_ok = !finished_q && !final_sent_q && (outstanding < eff_win);
  assign ack_off  = ack_seq_i - base_q;
  assign ack_ok   = !finished_q && (ack_off < diff);
  assign ack_plus = ack_seq_i + gbn_pkg::SEQ_BITS'(1);
  assign rs_seq   = base_q + gbn_pkg::SEQ_BITS'(cmd_i.idx);

  assign stat_o.out_free    = !ov_q || out_ready_i;
  assign stat_o.outstanding = outstanding;

  always_comb begin
    base_d       = base_q;
    next_d       = next_q;
    final_d      = final_q;
    final_sent_d = final_sent_q;
    finished_d   = finished_q;
    ov_d         = ov_q && !out_ready_i;
    kind_d       = kind_q;
    seq_d        = seq_q;
    slot_d       = slot_q;
    fin_d        = fin_q;
    done_d       = done_q;
    last_d       = last_q;
    if (cmd_i.do_offer) begin
      ov_d   = 1'b1;
      seq_d  = next_q;
      done_d = finished_q;
      last_d = 1'b1;
      if (offer_ok) begin
        kind_d = gbn_pkg::KIND_NEW;
        slot_d = gbn_pkg::SLOT_BITS'(next_q % gbn_pkg::WIN_MAX);
        fin_d  = chunk_final_i;
        next_d = next_q + gbn_pkg::SEQ_BITS'(1);
        if (chunk_final_i) begin
          final_sent_d = 1'b1;
          final_d      = next_q;
        end
      end else begin
        kind_d = gbn_pkg::KIND_REFUSE;
        slot_d = '0;
        fin_d  = 1'b0;
      end
    end else if (cmd_i.do_ack) begin
      ov_d   = 1'b1;
      kind_d = gbn_pkg::KIND_STATUS;
      slot_d = '0;
      fin_d  = 1'b0;
      last_d = 1'b1;
      seq_d  = base_q;
      done_d = finished_q;
      if (ack_ok) begin
        base_d = ack_plus;
        seq_d  = ack_plus;
        if (final_sent_q && (ack_seq_i == final_q)) begin
          finished_d = 1'b1;
          done_d     = 1'b1;
        end
      end
    end else if (cmd_i.do_resend) begin
      ov_d   = 1'b1;
      kind_d = gbn_pkg::KIND_RESEND;
      seq_d  = rs_seq;
      slot_d = gbn_pkg::SLOT_BITS'(rs_seq % gbn_pkg::WIN_MAX);
      fin_d  = final_sent_q && (rs_seq == final_q);
      done_d = finished_q;
      last_d = cmd_i.idx_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= gbn_pkg::WIN_RESET;
      base_q       <= '0;
      next_q       <= '0;
      final_q      <= '0;
      final_sent_q <= 1'b0;
      finished_q   <= 1'b0;
      ov_q         <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        win_q <= cfg_window_size_i;
      end
      base_q       <= base_d;
      next_q       <= next_d;
      final_q      <= final_d;
      final_sent_q <= final_sent_d;
      finished_q   <= finished_d;
      ov_q         <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    seq_q  <= seq_d;
    slot_q <= slot_d;
    fin_q  <= fin_d;
    done_q <= done_d;
    last_q <= last_d;
  end

  assign out_valid_o  = ov_q;
  assign kind_o       = kind_q;
  assign seq_o        = seq_q;
  assign slot_o       = slot_q;
  assign final_flag_o = fin_q;
  assign done_res_o   = done_q;
  assign last_o       = last_q;

endmodule

// File: hdl/go_back_n_send_window.sv
// Go-back-n send window, top level. A result word is registered and shows in the cycle after
// its input is taken. An offer or ack yields one word; a timeout with N outstanding (0 to 8)
// yields N resend words (none if N is 0) from the resend sequencer in gbn_ctrl, one per cycle
// while out_free. The input also stalls in any cycle where the held result word is not taken.
// Reset (rst_ni low, async): window empty, sequence numbers zero, window size 3.
// Uses gbn_pkg, gbn_ctrl and gbn_dp.
module go_back_n_send_window (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration: window size
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbn_pkg::WIN_BITS-1:0]  cfg_window_size_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    cmd_i,
  input  logic [gbn_pkg::SEQ_BITS-1:0]  ack_seq_i,
  input  logic                          chunk_final_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    kind_o,
  output logic [gbn_pkg::SEQ_BITS-1:0]  seq_o,
  output logic [gbn_pkg::SLOT_BITS-1:0] slot_o,
  output logic                          final_flag_o,
  output logic                          done_res_o,
  output logic                          last_o
);

  gbn_pkg::gbn_cmd_t  cmd;
  gbn_pkg::gbn_stat_t stat;

  // The window size register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // Controller: accept a word when idle and the result register is free (or
  // being drained this cycle); step through the resend run after a timeout.
  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: hold base/next/final state, evaluate offers and acks, and
  // register each result word until the consumer takes it.
  gbn_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_window_size_i (cfg_window_size_i),
    .ack_seq_i         (ack_seq_i),
    .chunk_final_i     (chunk_final_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .kind_o            (kind_o),
    .seq_o             (seq_o),
    .slot_o            (slot_o),
    .final_flag_o      (final_flag_o),
    .done_res_o        (done_res_o),
    .last_o            (last_o)
  );

  // An offer or ack always leaves a single, final result word behind.
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (cmd_i == gbn_pkg::CMD_OFFER || cmd_i == gbn_pkg::CMD_ACK))
    |=> (out_valid_o && last_o))
    else $error("offer/ack did not produce one final result word");

  // No new word is taken while a resend run is still in progress.
  a_resend_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == gbn_pkg::KIND_RESEND && !last_o) |-> !in_ready_o)
    else $error("input accepted in the middle of a resend run");

  // A new send uses the buffer slot of its sequence number.
  a_slot_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == gbn_pkg::KIND_NEW)
    |-> (slot_o == seq_o[gbn_pkg::SLOT_BITS-1:0]))
    else $error("new send slot does not match its sequence number");

endmodule
